// ===== hdl/slgc_pkg.sv =====
// slgc_pkg: constants, palette slopes and sine table for the sine-luma gold colorizer.
// No dependencies. The sine table is computed at elaboration in Q60 fixed point.
`default_nettype none

package slgc_pkg;

	localparam int TABLE_BITS = 10;
	localparam int TBL_SIZE   = 1 << TABLE_BITS;
	localparam int TBL_HALF   = TBL_SIZE / 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd1;

	localparam logic [15:0] PERIOD_RST = 16'd256;

	// luma weights, Q0.10
	localparam logic [8:0] W_RED   = 9'd307;
	localparam logic [9:0] W_GREEN = 10'd604;
	localparam logic [6:0] W_BLUE  = 7'd113;

	// palette, Q8.8 slopes
	localparam logic [9:0] SLOPE_R_LO  = 10'd883;
	localparam logic [9:0] SLOPE_R_MID = 10'd166;
	localparam logic [9:0] SLOPE_G_MID = 10'd346;
	localparam logic [9:0] SLOPE_B_MID = 10'd128;
	localparam logic [9:0] SLOPE_B_HI  = 10'd525;
	localparam logic [7:0] KNEE_LO     = 8'd55;
	localparam logic [7:0] KNEE_HI     = 8'd155;
	localparam logic [7:0] BASE_190    = 8'd190;
	localparam logic [7:0] BASE_50     = 8'd50;
	localparam logic [7:0] FULL        = 8'hff;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] M32    = 64'h00000000FFFFFFFF;

	typedef logic [7:0] sine_tab_t [TBL_SIZE];

	// (a*b) >> 60, a and b below 2^62
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] a0, a1, b0, b1, p00, p01, p10, p11, mid, hi, lo;
		a0  = a & M32;
		a1  = a >> 32;
		b0  = b & M32;
		b1  = b >> 32;
		p00 = a0 * b0;
		p01 = a0 * b1;
		p10 = a1 * b0;
		p11 = a1 * b1;
		mid = (p00 >> 32) + (p01 & M32) + (p10 & M32);
		hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
		lo  = ((mid & M32) << 32) | (p00 & M32);
		return (hi << 4) | (lo >> 60);
	endfunction

	// restoring shift-subtract divide, quotient only
	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int j = 63; j >= 0; j--) begin
			rem = {rem[63:0], num[j]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[j] = 1'b1;
			end
		end
		return quo;
	endfunction

	// floor(255*sin(pi*i/TBL_SIZE)) for i up to TBL_SIZE/2
	function automatic logic [7:0] sine_entry(input int unsigned i);
		logic [63:0] x, x2, t, s, hi, lo, v, dv;
		int unsigned k;
		logic        run;
		if (i == 0) return 8'd0;
		if (i == TBL_HALF) return 8'd255;
		x   = (PI_Q60 >> TABLE_BITS) * 64'(i);
		x2  = mul_q60(x, x);
		t   = x;
		s   = x;
		run = 1'b1;
		for (k = 1; k < 40; k++) begin
			if (run) begin
				dv = 64'((2 * k) * (2 * k + 1));
				t  = div_u64(mul_q60(t, x2), dv);
				if (k[0]) begin
					s = s - t;
				end else begin
					s = s + t;
				end
				if (t == 64'd0) run = 1'b0;
			end
		end
		hi = s >> 30;
		lo = s & ((64'd1 << 30) - 64'd1);
		v  = (hi * 64'd255 + ((lo * 64'd255) >> 30)) >> 30;
		return (v > 64'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		int unsigned f;
		for (int unsigned i = 0; i < TBL_SIZE; i++) begin
			f      = (i <= TBL_HALF) ? i : TBL_SIZE - i;
			tab[i] = sine_entry(f);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ===== hdl/sine_luma_golden_colorize_unit.sv =====
// Sine-luma gold colorizer: luma, folded-sine phase and gold palette per pixel.
// Depends on slgc_pkg (weights, slopes, sine table).
// start passes through the stage 1-3 valid registers and the done register; throughput one pixel per cycle.
// busy is always low: the pipeline never stalls and the receiver cannot hold off.
// Reset clears valid bits and restores period_q = 256, enable = 1.
`default_nettype none

module sine_luma_golden_colorize_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [7:0]                       in_red,
	input  wire logic [7:0]                       in_green,
	input  wire logic [7:0]                       in_blue,
	input  wire logic [7:0]                       in_alpha,
	input  wire logic                             in_last,
	input  wire logic                             wr_en,
	input  wire logic [slgc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [slgc_pkg::CFG_DATA_W-1:0]  wr_data,
	output logic                                  done,
	output logic [7:0]                            out_red,
	output logic [7:0]                            out_green,
	output logic [7:0]                            out_blue,
	output logic [7:0]                            out_alpha,
	output logic                                  out_last
);
	import slgc_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
		logic       en;
	} pix_t;

	logic [15:0] period_q;
	logic        enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			enable_q <= 1'b1;
		end else if (wr_en) begin
			if (wr_index == REG_PERIOD) period_q <= wr_data[15:0];
			if (wr_index == REG_ENABLE) enable_q <= wr_data[0];
		end
	end

	assign busy = 1'b0;

	// stage 1: luma
	logic [17:0] luma_sum;
	assign luma_sum = 18'(W_RED) * 18'(in_red) + 18'(W_GREEN) * 18'(in_green)
		+ 18'(W_BLUE) * 18'(in_blue);

	logic       vld_s1, vld_s2, vld_s3;
	pix_t       pix_s1, pix_s2, pix_s3;
	logic [7:0] luma_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pix_s1  <= '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha,
				last: in_last, en: enable_q};
			luma_s1 <= luma_sum[17:10];
		end
	end

	// stage 2: phase, table index
	logic [23:0]           phase_full;
	logic [TABLE_BITS-1:0] idx_s2;
	assign phase_full = luma_s1 * period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			pix_s2 <= pix_s1;
			idx_s2 <= phase_full[15 -: TABLE_BITS];
		end
	end

	// stage 3: sine lookup
	logic [7:0] sine_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			pix_s3  <= pix_s2;
			sine_s3 <= SINE_TAB[idx_s2];
		end
	end

	// stage 4: gold palette
	logic [7:0]  dmid, dhi;
	logic [17:0] prod_r_lo, prod_r_mid, prod_g_mid, prod_b_mid, prod_g_hi, prod_b_hi;
	logic [10:0] sum_r, sum_g, sum_b;
	logic [7:0]  pal_r, pal_g, pal_b;

	assign dmid       = sine_s3 - KNEE_LO;
	assign dhi        = sine_s3 - KNEE_HI;
	assign prod_r_lo  = SLOPE_R_LO * sine_s3;
	assign prod_r_mid = SLOPE_R_MID * dmid;
	assign prod_g_mid = SLOPE_G_MID * dmid;
	assign prod_b_mid = SLOPE_B_MID * dmid;
	assign prod_g_hi  = SLOPE_R_MID * dhi;
	assign prod_b_hi  = SLOPE_B_HI * dhi;

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		priority if (sine_s3 <= KNEE_LO) begin
			sum_r = prod_r_lo[17:8] + 11'd0;
			sum_g = {3'd0, sine_s3};
			sum_b = '0;
		end else if (sine_s3 <= KNEE_HI) begin
			sum_r = 11'(BASE_190) + prod_r_mid[17:8];
			sum_g = 11'(KNEE_LO) + prod_g_mid[17:8];
			sum_b = {1'b0, prod_b_mid[17:8]};
		end else begin
			sum_r = 11'(FULL);
			sum_g = 11'(BASE_190) + prod_g_hi[17:8];
			sum_b = 11'(BASE_50) + prod_b_hi[17:8];
		end
		pal_r = (sum_r > 11'(FULL)) ? FULL : sum_r[7:0];
		pal_g = (sum_g > 11'(FULL)) ? FULL : sum_g[7:0];
		pal_b = (sum_b > 11'(FULL)) ? FULL : sum_b[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			out_red   <= pix_s3.en ? pal_r : pix_s3.red;
			out_green <= pix_s3.en ? pal_g : pix_s3.green;
			out_blue  <= pix_s3.en ? pal_b : pix_s3.blue;
			out_alpha <= pix_s3.alpha;
			out_last  <= pix_s3.last;
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for sine_luma_golden_colorize_unit; holds its own
// luma / folded-sine / gold-palette predictor and a per-field result checker.
// Depends on slgc_pkg and hdl/sine_luma_golden_colorize_unit.sv.

module tb_top;
	import slgc_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int LATENCY       = 4;
	localparam int DRAIN_LIMIT   = 200;
	localparam int MAX_PRINTS    = 100;
	localparam int RANDOM_BLOCKS = 12;
	localparam int BLOCK_ITEMS   = 104;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
	localparam logic [63:0]          PI_FRAC_Q60  = 64'h3243F6A8885A308D;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} pixel_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  start    = 1'b0;
	logic                  busy;
	logic [7:0]            in_red   = '0;
	logic [7:0]            in_green = '0;
	logic [7:0]            in_blue  = '0;
	logic [7:0]            in_alpha = '0;
	logic                  in_last  = 1'b0;
	logic                  wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = REG_PERIOD;
	logic [CFG_DATA_W-1:0] wr_data  = '0;
	logic                  done;
	logic [7:0]            out_red;
	logic [7:0]            out_green;
	logic [7:0]            out_blue;
	logic [7:0]            out_alpha;
	logic                  out_last;

	logic [7:0]  sine_lut [TBL_SIZE];
	logic [15:0] period_cfg;
	logic        enable_cfg;
	pixel_t      pending_pixels [$];
	int unsigned error_count = 0;
	int unsigned print_count = 0;
	int unsigned idle_pct    = 0;

	sine_luma_golden_colorize_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.in_alpha  (in_alpha),
		.in_last   (in_last),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.done      (done),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha),
		.out_last  (out_last)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// floor(255*sin(pi*f/TBL_SIZE)), Q60 Taylor series, f up to TBL_SIZE/2
	function automatic logic [7:0] folded_sine(int unsigned f);
		logic [127:0] x, x2, t, s, v;
		if (f == 0) return 8'd0;
		if (f == TBL_SIZE / 2) return 8'd255;
		x  = 128'(PI_FRAC_Q60 >> TABLE_BITS) * 128'(f);
		x2 = (x * x) >> 60;
		t  = x;
		s  = x;
		for (int k = 1; k < 40 && t != 0; k++) begin
			t = ((t * x2) >> 60) / 128'((2 * k) * (2 * k + 1));
			s = (k % 2 == 1) ? s - t : s + t;
		end
		v = (s * 128'd255) >> 60;
		return (v > 128'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic [7:0] sat8(int unsigned v);
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic pixel_t colorize_pixel(pixel_t p);
		pixel_t      q;
		int unsigned luma, phase, s, d;
		q = p;
		if (enable_cfg) begin
			luma  = (32'(p.red) * 307 + 32'(p.green) * 604 + 32'(p.blue) * 113) >> 10;
			phase = (luma * 32'(period_cfg)) & 32'hFFFF;
			s     = 32'(sine_lut[TABLE_BITS'(phase >> (16 - TABLE_BITS))]);
			if (s <= 55) begin
				q.red   = sat8((883 * s) >> 8);
				q.green = sat8(s);
				q.blue  = 8'd0;
			end else if (s <= 155) begin
				d       = s - 55;
				q.red   = sat8(190 + ((166 * d) >> 8));
				q.green = sat8(55 + ((346 * d) >> 8));
				q.blue  = sat8((128 * d) >> 8);
			end else begin
				d       = s - 155;
				q.red   = 8'd255;
				q.green = sat8(190 + ((166 * d) >> 8));
				q.blue  = sat8(50 + ((525 * d) >> 8));
			end
		end
		return q;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (print_count < MAX_PRINTS) begin
			print_count++;
			$display("mismatch at %0t: %s", $time, msg);
		end
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// request accepted: predict its result
	always @(posedge clk) begin
		if (arst_n && start === 1'b1 && busy === 1'b0)
			pending_pixels.push_back(colorize_pixel(
				pixel_t'({in_red, in_green, in_blue, in_alpha, in_last})));
	end

	always @(posedge clk) begin : result_check
		pixel_t want;
		if (done === 1'b1) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = pending_pixels.pop_front();
				check_field("red", out_red, want.red);
				check_field("green", out_green, want.green);
				check_field("blue", out_blue, want.blue);
				check_field("alpha", out_alpha, want.alpha);
				check_field("last", {7'd0, out_last}, {7'd0, want.last});
			end
		end
	end

	task automatic send_pixel(pixel_t p);
		start    <= 1'b1;
		in_red   <= p.red;
		in_green <= p.green;
		in_blue  <= p.blue;
		in_alpha <= p.alpha;
		in_last  <= p.last;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// each cycle idles with probability idle_pct percent
	task automatic sender_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		case (idx)
			REG_PERIOD: period_cfg = data;
			REG_ENABLE: enable_cfg = data[0];
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int unsigned waited;
		waited = 0;
		start <= 1'b0;
		while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
			pending_pixels.delete();
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a, logic l);
		return pixel_t'({r, g, b, a, l});
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t     p;
		logic [7:0] g;
		p.red   = 8'($urandom);
		p.green = 8'($urandom);
		p.blue  = 8'($urandom);
		p.alpha = 8'($urandom);
		p.last  = ($urandom_range(7) == 0);
		g       = 8'($urandom);
		case ($urandom_range(9))
			0, 1: begin
				p.red   = g;
				p.green = g;
				p.blue  = g;
			end
			2: begin
				p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
				p.green = $urandom_range(1) ? 8'hFF : 8'h00;
				p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			3: begin
				p.red   = g ^ 8'($urandom_range(3));
				p.green = g ^ 8'($urandom_range(3));
				p.blue  = g ^ 8'($urandom_range(3));
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic test_defaults();
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 8'h5A, 1'b0));
		send_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 8'hA5, 1'b1));
		wait_drained();
	endtask

	// gray input gives luma = level; walks all three palette segments
	task automatic test_gray_ramp();
		logic [7:0] levels [8];
		levels = '{8'd0, 8'd16, 8'd32, 8'd64, 8'd100, 8'd128, 8'd200, 8'd255};
		write_reg(REG_PERIOD, PERIOD_RST);
		foreach (levels[i])
			send_pixel(make_pixel(levels[i], levels[i], levels[i], 8'(i), i[0]));
		wait_drained();
	endtask

	task automatic test_period_extremes();
		write_reg(REG_PERIOD, 16'h0000);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
		send_pixel(make_pixel(8'h80, 8'h40, 8'hC0, 8'h01, 1'b1));
		wait_drained();
		write_reg(REG_PERIOD, 16'hFFFF);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0));
		send_pixel(make_pixel(8'h01, 8'h01, 8'h01, 8'h80, 1'b1));
		send_pixel(make_pixel(8'h7F, 8'hFE, 8'h33, 8'h7F, 1'b0));
		wait_drained();
	endtask

	task automatic test_disable_and_bad_index();
		write_reg(REG_ENABLE, 16'hFFFE);
		send_pixel(make_pixel(8'hFF, 8'h00, 8'hAA, 8'h55, 1'b1));
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h55, 8'hAA, 1'b0));
		send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b1));
		wait_drained();
		write_reg(REG_UNUSED_A, 16'h0001);
		write_reg(REG_UNUSED_B, 16'hFFFF);
		send_pixel(make_pixel(8'h9C, 8'h3E, 8'hF1, 8'h0F, 1'b0));
		wait_drained();
		write_reg(REG_ENABLE, 16'h8001);
		write_reg(REG_PERIOD, 16'd300);
		write_reg(REG_UNUSED_A, 16'h0000);
		write_reg(REG_UNUSED_B, 16'h0100);
		send_pixel(make_pixel(8'hC8, 8'hC8, 8'hC8, 8'hF0, 1'b1));
		send_pixel(make_pixel(8'h40, 8'h90, 8'h20, 8'h0E, 1'b0));
		wait_drained();
	endtask

	task automatic test_random_stream();
		logic [15:0] period_val;
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			idle_pct = (b < 4) ? 18 : (b < 8) ? 59 : 0;
			wait_drained();
			case ($urandom_range(4))
				0: period_val = 16'h0000;
				1: period_val = 16'hFFFF;
				2: period_val = 16'($urandom_range(1, 32));
				3: period_val = PERIOD_RST;
				default: period_val = 16'($urandom);
			endcase
			write_reg(REG_PERIOD, period_val);
			if ($urandom_range(7) == 0)
				write_reg(REG_ENABLE, 16'($urandom) & 16'hFFFE);
			else
				write_reg(REG_ENABLE, 16'($urandom) | 16'h0001);
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, 16'($urandom));
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				sender_gap();
				send_pixel(random_pixel());
			end
		end
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < TBL_SIZE; i++)
			sine_lut[i] = folded_sine((i <= TBL_SIZE / 2) ? i : TBL_SIZE - i);
		period_cfg = PERIOD_RST;
		enable_cfg = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_gray_ramp();
		test_period_extremes();
		test_disable_and_bad_index();
		test_random_stream();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
